// File: rtl/hs_pkg.sv
// ---------------------------------------------------------------------------
// hs_pkg
// shared types, constants and round functions of the hmac-sha256 engine
// ---------------------------------------------------------------------------
package hs_pkg;

    localparam int unsigned BLOCK_BITS = 512;
    localparam logic [7:0]  IPAD_BYTE  = 8'h36;
    localparam logic [7:0]  OPAD_BYTE  = 8'h5c;
    localparam logic [7:0]  MARK_BYTE  = 8'h80;
    localparam logic [5:0]  LEN_FILL   = 6'd56;
    localparam logic [6:0]  KEY_BYTES  = 7'd64;

    typedef struct packed {
        logic       req_type;
        logic [7:0] data_byte;
        logic       last;
    } item_t;

    localparam logic [31:0] IV [0:7] = '{
        32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
        32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
    };

    localparam logic [31:0] RK [0:63] = '{
        32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
        32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
        32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
        32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
        32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
        32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
        32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
        32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
        32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
        32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
        32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
        32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
        32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
        32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
        32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
        32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
    };

    function automatic logic [31:0] rotr(input logic [31:0] x, input int unsigned n);
        rotr = (x >> n) | (x << (32 - n));
    endfunction

    function automatic logic [31:0] big_s0(input logic [31:0] x);
        big_s0 = rotr(x, 2) ^ rotr(x, 13) ^ rotr(x, 22);
    endfunction

    function automatic logic [31:0] big_s1(input logic [31:0] x);
        big_s1 = rotr(x, 6) ^ rotr(x, 11) ^ rotr(x, 25);
    endfunction

    function automatic logic [31:0] small_s0(input logic [31:0] x);
        small_s0 = rotr(x, 7) ^ rotr(x, 18) ^ (x >> 3);
    endfunction

    function automatic logic [31:0] small_s1(input logic [31:0] x);
        small_s1 = rotr(x, 17) ^ rotr(x, 19) ^ (x >> 10);
    endfunction

    // byte lane 0 is the most significant byte
    function automatic logic [7:0] word_byte(input logic [31:0] w, input logic [1:0] lane);
        logic [31:0] s;
        s = w >> (5'd24 - {lane, 3'b000});
        word_byte = s[7:0];
    endfunction

endpackage

// File: rtl/hs_front.sv
// ---------------------------------------------------------------------------
// hs_front
// input side: takes stream items into a two-entry queue for the back end
// ---------------------------------------------------------------------------
module hs_front
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          in_valid,
    output logic          in_ready,
    input  hs_pkg::item_t in_item,
    output logic          out_valid,
    input  logic          out_ready,
    output hs_pkg::item_t out_item
);

    hs_pkg::item_t ent_reg [2];
    logic          wr_ptr_reg;
    logic          rd_ptr_reg;
    logic [1:0]    used_reg;
    logic          push;
    logic          pop;

    assign in_ready  = (used_reg != 2'd2);
    assign out_valid = (used_reg != 2'd0);
    assign out_item  = ent_reg[rd_ptr_reg];
    assign push      = in_valid && in_ready;
    assign pop       = out_valid && out_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            used_reg   <= 2'd0;
            ent_reg[0] <= '0;
            ent_reg[1] <= '0;
        end
        else
        begin
            if (push)
            begin
                ent_reg[wr_ptr_reg] <= in_item;
                wr_ptr_reg          <= ~wr_ptr_reg;
            end
            if (pop)
            begin
                rd_ptr_reg <= ~rd_ptr_reg;
            end
            case ({push, pop})
                2'b10:   used_reg <= used_reg + 2'd1;
                2'b01:   used_reg <= used_reg - 2'd1;
                default: used_reg <= used_reg;
            endcase
        end
    end

endmodule

// File: rtl/hs_back.sv
// ---------------------------------------------------------------------------
// hs_back
// sequencer, key store and sha-256 round datapath; drives the result register
// ---------------------------------------------------------------------------
module hs_back
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          in_valid,
    output logic          in_ready,
    input  hs_pkg::item_t in_item,
    output logic          m_valid,
    input  logic          m_ready,
    output logic [31:0]   m_word,
    output logic [2:0]    m_idx,
    output logic          m_last
);

    typedef enum logic [3:0] {
        ST_IDLE, ST_DISPATCH, ST_FEED_KEY, ST_FEED_BYTE, ST_FEED_INNER,
        ST_PAD, ST_ROUND, ST_ADD, ST_OUT
    } state_t;

    typedef enum logic [1:0] {PH_IDLE, PH_KEY, PH_MSG} phase_t;
    typedef enum logic [1:0] {PK_KEY, PK_INNER, PK_OUTER} pad_kind_t;
    typedef enum logic [1:0] {PS_MARK, PS_ZERO, PS_LEN, PS_DONE} pad_stage_t;
    typedef enum logic [1:0] {KS_PLAIN, KS_IPAD, KS_OPAD} key_src_t;

    state_t        state_reg, state_next;
    state_t        ret_reg, ret_next;
    phase_t        phase_reg, phase_next;
    pad_kind_t     pad_kind_reg, pad_kind_next;
    pad_stage_t    pad_stage_reg, pad_stage_next;
    key_src_t      key_src_reg, key_src_next;
    hs_pkg::item_t item_reg, item_next;
    logic [31:0]   key_reg [16];
    logic [31:0]   key_next [16];
    logic [31:0]   inner_reg [8];
    logic [31:0]   inner_next [8];
    logic [31:0]   chain_reg [8];
    logic [31:0]   chain_next [8];
    logic [31:0]   work_reg [8];
    logic [31:0]   work_next [8];
    logic [hs_pkg::BLOCK_BITS-1:0] blk_reg, blk_next;
    logic [5:0]    fill_reg, fill_next;
    logic [63:0]   bits_reg, bits_next;
    logic [5:0]    rnd_reg, rnd_next;
    logic [5:0]    cnt_reg, cnt_next;
    logic [6:0]    count_reg, count_next;
    logic          hashing_reg, hashing_next;
    logic          fdone_reg, fdone_next;
    logic [2:0]    ocnt_reg, ocnt_next;
    logic          m_valid_reg, m_valid_next;
    logic [31:0]   m_word_reg, m_word_next;
    logic [2:0]    m_idx_reg, m_idx_next;
    logic          m_last_reg, m_last_next;

    assign in_ready = (state_reg == ST_IDLE);
    assign m_valid  = m_valid_reg;
    assign m_word   = m_word_reg;
    assign m_idx    = m_idx_reg;
    assign m_last   = m_last_reg;

    always_comb
    begin
        logic        fire;
        logic        fcount;
        logic        flast;
        logic [7:0]  fb;
        logic        sha_go;
        logic        msg_go;
        logic [31:0] kw;
        logic [31:0] t1;
        logic [31:0] t2;
        logic [31:0] nw;
        logic [63:0] lsh;

        fire   = 1'b0;
        fcount = 1'b0;
        flast  = 1'b0;
        fb     = 8'h00;
        sha_go = 1'b0;
        msg_go = 1'b0;
        kw     = '0;
        t1     = '0;
        t2     = '0;
        nw     = '0;
        lsh    = '0;

        state_next     = state_reg;
        ret_next       = ret_reg;
        phase_next     = phase_reg;
        pad_kind_next  = pad_kind_reg;
        pad_stage_next = pad_stage_reg;
        key_src_next   = key_src_reg;
        item_next      = item_reg;
        key_next       = key_reg;
        inner_next     = inner_reg;
        chain_next     = chain_reg;
        work_next      = work_reg;
        blk_next       = blk_reg;
        fill_next      = fill_reg;
        bits_next      = bits_reg;
        rnd_next       = rnd_reg;
        cnt_next       = cnt_reg;
        count_next     = count_reg;
        hashing_next   = hashing_reg;
        fdone_next     = fdone_reg;
        ocnt_next      = ocnt_reg;
        m_valid_next   = m_ready ? 1'b0 : m_valid_reg;
        m_word_next    = m_word_reg;
        m_idx_next     = m_idx_reg;
        m_last_next    = m_last_reg;

        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    item_next  = in_item;
                    state_next = ST_DISPATCH;
                end
            end

            ST_DISPATCH:
            begin
                if (!item_reg.req_type)
                begin
                    if (phase_reg != PH_KEY)
                    begin
                        for (int i = 0; i < 16; i++)
                        begin
                            key_next[i] = '0;
                        end
                        count_next   = '0;
                        hashing_next = 1'b0;
                        phase_next   = PH_KEY;
                    end
                    if (hashing_next)
                    begin
                        state_next = ST_FEED_BYTE;
                    end
                    else if (count_next < hs_pkg::KEY_BYTES)
                    begin
                        // big-endian lane within the key word
                        kw = key_next[count_next[5:2]];
                        case (count_next[1:0])
                            2'd0:    kw[31:24] = item_reg.data_byte;
                            2'd1:    kw[23:16] = item_reg.data_byte;
                            2'd2:    kw[15:8]  = item_reg.data_byte;
                            default: kw[7:0]   = item_reg.data_byte;
                        endcase
                        key_next[count_next[5:2]] = kw;
                        count_next = count_next + 7'd1;
                        if (item_reg.last)
                        begin
                            phase_next = PH_IDLE;
                        end
                        state_next = ST_IDLE;
                    end
                    else
                    begin
                        // key overflows the store: hash stored bytes, then this one
                        sha_go       = 1'b1;
                        key_src_next = KS_PLAIN;
                        cnt_next     = '0;
                        hashing_next = 1'b1;
                        state_next   = ST_FEED_KEY;
                    end
                end
                else
                begin
                    if (phase_reg == PH_KEY && hashing_reg)
                    begin
                        pad_kind_next  = PK_KEY;
                        pad_stage_next = PS_MARK;
                        state_next     = ST_PAD;
                    end
                    else if (phase_reg == PH_MSG)
                    begin
                        state_next = ST_FEED_BYTE;
                    end
                    else
                    begin
                        msg_go = 1'b1;
                    end
                end
            end

            ST_FEED_KEY:
            begin
                if (fdone_reg)
                begin
                    fdone_next = 1'b0;
                    cnt_next   = '0;
                    state_next = (key_src_reg == KS_OPAD) ? ST_FEED_INNER : ST_FEED_BYTE;
                end
                else
                begin
                    fire   = 1'b1;
                    fcount = 1'b1;
                    flast  = (cnt_reg == 6'd63);
                    fb     = hs_pkg::word_byte(key_reg[cnt_reg[5:2]], cnt_reg[1:0]);
                    case (key_src_reg)
                        KS_IPAD: fb = fb ^ hs_pkg::IPAD_BYTE;
                        KS_OPAD: fb = fb ^ hs_pkg::OPAD_BYTE;
                        default: fb = fb;
                    endcase
                    cnt_next = cnt_reg + 6'd1;
                end
            end

            ST_FEED_INNER:
            begin
                if (fdone_reg)
                begin
                    fdone_next     = 1'b0;
                    pad_kind_next  = PK_OUTER;
                    pad_stage_next = PS_MARK;
                    state_next     = ST_PAD;
                end
                else
                begin
                    fire     = 1'b1;
                    fcount   = 1'b1;
                    flast    = (cnt_reg == 6'd31);
                    fb       = hs_pkg::word_byte(inner_reg[cnt_reg[4:2]], cnt_reg[1:0]);
                    cnt_next = cnt_reg + 6'd1;
                end
            end

            ST_FEED_BYTE:
            begin
                if (fdone_reg)
                begin
                    fdone_next = 1'b0;
                    if (item_reg.last)
                    begin
                        pad_kind_next  = item_reg.req_type ? PK_INNER : PK_KEY;
                        pad_stage_next = PS_MARK;
                        state_next     = ST_PAD;
                    end
                    else
                    begin
                        state_next = ST_IDLE;
                    end
                end
                else
                begin
                    fire   = 1'b1;
                    fcount = 1'b1;
                    flast  = 1'b1;
                    fb     = item_reg.data_byte;
                end
            end

            ST_PAD:
            begin
                case (pad_stage_reg)
                    PS_MARK:
                    begin
                        fire           = 1'b1;
                        fb             = hs_pkg::MARK_BYTE;
                        pad_stage_next = PS_ZERO;
                    end
                    PS_ZERO:
                    begin
                        if (fill_reg == hs_pkg::LEN_FILL)
                        begin
                            pad_stage_next = PS_LEN;
                            cnt_next       = '0;
                        end
                        else
                        begin
                            fire = 1'b1;
                        end
                    end
                    PS_LEN:
                    begin
                        fire = 1'b1;
                        lsh  = bits_reg >> (6'd56 - {cnt_reg[2:0], 3'b000});
                        fb   = lsh[7:0];
                        cnt_next = cnt_reg + 6'd1;
                        if (cnt_reg[2:0] == 3'd7)
                        begin
                            pad_stage_next = PS_DONE;
                        end
                    end
                    default:
                    begin
                        case (pad_kind_reg)
                            PK_KEY:
                            begin
                                for (int i = 0; i < 16; i++)
                                begin
                                    key_next[i] = (i < 8) ? chain_reg[i[2:0]] : '0;
                                end
                                count_next   = hs_pkg::KEY_BYTES;
                                hashing_next = 1'b0;
                                phase_next   = PH_IDLE;
                                if (item_reg.req_type)
                                begin
                                    msg_go = 1'b1;
                                end
                                else
                                begin
                                    state_next = ST_IDLE;
                                end
                            end
                            PK_INNER:
                            begin
                                inner_next   = chain_reg;
                                sha_go       = 1'b1;
                                key_src_next = KS_OPAD;
                                cnt_next     = '0;
                                state_next   = ST_FEED_KEY;
                            end
                            default:
                            begin
                                phase_next = PH_IDLE;
                                ocnt_next  = '0;
                                state_next = ST_OUT;
                            end
                        endcase
                    end
                endcase
            end

            ST_ROUND:
            begin
                t1 = work_reg[7] + hs_pkg::big_s1(work_reg[4])
                   + ((work_reg[4] & work_reg[5]) ^ (~work_reg[4] & work_reg[6]))
                   + hs_pkg::RK[rnd_reg] + blk_reg[511:480];
                t2 = hs_pkg::big_s0(work_reg[0])
                   + ((work_reg[0] & work_reg[1]) ^ (work_reg[0] & work_reg[2])
                   ^ (work_reg[1] & work_reg[2]));
                work_next[7] = work_reg[6];
                work_next[6] = work_reg[5];
                work_next[5] = work_reg[4];
                work_next[4] = work_reg[3] + t1;
                work_next[3] = work_reg[2];
                work_next[2] = work_reg[1];
                work_next[1] = work_reg[0];
                work_next[0] = t1 + t2;
                // window word i holds w[t+i]; append w[t+16]
                nw = hs_pkg::small_s1(blk_reg[63:32]) + blk_reg[223:192]
                   + hs_pkg::small_s0(blk_reg[479:448]) + blk_reg[511:480];
                blk_next = {blk_reg[479:0], nw};
                rnd_next = rnd_reg + 6'd1;
                if (rnd_reg == 6'd63)
                begin
                    state_next = ST_ADD;
                end
            end

            ST_ADD:
            begin
                for (int i = 0; i < 8; i++)
                begin
                    chain_next[i] = chain_reg[i] + work_reg[i];
                end
                state_next = ret_reg;
            end

            ST_OUT:
            begin
                if (!m_valid_reg || m_ready)
                begin
                    m_valid_next = 1'b1;
                    m_word_next  = chain_reg[ocnt_reg];
                    m_idx_next   = ocnt_reg;
                    m_last_next  = (ocnt_reg == 3'd7);
                    ocnt_next    = ocnt_reg + 3'd1;
                    if (ocnt_reg == 3'd7)
                    begin
                        state_next = ST_IDLE;
                    end
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase

        // start of the inner hash: ipad block, then the message byte
        if (msg_go)
        begin
            sha_go       = 1'b1;
            key_src_next = KS_IPAD;
            cnt_next     = '0;
            phase_next   = PH_MSG;
            state_next   = ST_FEED_KEY;
        end

        if (sha_go)
        begin
            chain_next = hs_pkg::IV;
            fill_next  = '0;
            bits_next  = '0;
        end

        if (fire)
        begin
            blk_next  = {blk_reg[hs_pkg::BLOCK_BITS-9:0], fb};
            fill_next = fill_reg + 6'd1;
            if (fcount)
            begin
                bits_next = bits_reg + 64'd8;
            end
            if (flast)
            begin
                fdone_next = 1'b1;
            end
            // full block: compress, then come back here
            if (fill_reg == 6'd63)
            begin
                ret_next   = state_reg;
                state_next = ST_ROUND;
                rnd_next   = '0;
                work_next  = chain_reg;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            ret_reg       <= ST_IDLE;
            phase_reg     <= PH_IDLE;
            pad_kind_reg  <= PK_KEY;
            pad_stage_reg <= PS_MARK;
            key_src_reg   <= KS_PLAIN;
            item_reg      <= '0;
            key_reg       <= '{default: '0};
            inner_reg     <= '{default: '0};
            chain_reg     <= hs_pkg::IV;
            work_reg      <= '{default: '0};
            blk_reg       <= '0;
            fill_reg      <= '0;
            bits_reg      <= '0;
            rnd_reg       <= '0;
            cnt_reg       <= '0;
            count_reg     <= '0;
            hashing_reg   <= 1'b0;
            fdone_reg     <= 1'b0;
            ocnt_reg      <= '0;
            m_valid_reg   <= 1'b0;
            m_word_reg    <= '0;
            m_idx_reg     <= '0;
            m_last_reg    <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            ret_reg       <= ret_next;
            phase_reg     <= phase_next;
            pad_kind_reg  <= pad_kind_next;
            pad_stage_reg <= pad_stage_next;
            key_src_reg   <= key_src_next;
            item_reg      <= item_next;
            key_reg       <= key_next;
            inner_reg     <= inner_next;
            chain_reg     <= chain_next;
            work_reg      <= work_next;
            blk_reg       <= blk_next;
            fill_reg      <= fill_next;
            bits_reg      <= bits_next;
            rnd_reg       <= rnd_next;
            cnt_reg       <= cnt_next;
            count_reg     <= count_next;
            hashing_reg   <= hashing_next;
            fdone_reg     <= fdone_next;
            ocnt_reg      <= ocnt_next;
            m_valid_reg   <= m_valid_next;
            m_word_reg    <= m_word_next;
            m_idx_reg     <= m_idx_next;
            m_last_reg    <= m_last_next;
        end
    end

`ifndef SYNTHESIS
    a_round_on_full_block: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_ROUND && rnd_reg == 6'd0) |-> (fill_reg == 6'd0))
        else $error("compression started with a partial block");

    a_key_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= hs_pkg::KEY_BYTES)
        else $error("key count beyond store size");

    a_add_returns: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_ADD) |=> (state_reg == $past(ret_reg)))
        else $error("chain update did not return to the feeding step");

    a_last_word_index: assert property (@(posedge clk) disable iff (!rst_n)
        (m_valid_reg && m_last_reg) |-> (m_idx_reg == 3'd7))
        else $error("final word flag on a word other than the eighth");

    a_length_position: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_PAD && pad_stage_reg == PS_LEN) |-> (fill_reg >= hs_pkg::LEN_FILL))
        else $error("length field placed before byte 56");
`endif

endmodule

// File: rtl/hmac_sha256_engine.sv
// ---------------------------------------------------------------------------
// hmac_sha256_engine
// streaming hmac-sha256 over one key or message byte per item
// ---------------------------------------------------------------------------
// Items carry one byte each: tuser 0 = key byte, 1 = message byte, tlast
// closes the key or the message. The key is kept across messages; a key of
// more than 64 bytes is replaced by its sha-256 digest. On the last message
// byte eight result items follow, digest word 0 (most significant) first,
// tlast on word 7. A two-entry input queue lets the stream run ahead of the
// sequencer, and a result register holds each word until taken. The
// sequencer handles one item at a time, and every full 64-byte block passes
// through the single round unit (64 rounds and the chain update). Besides
// its bytes, a message hashes the ipad, opad and padding blocks at its
// start and end.
module hmac_sha256_engine
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] data_byte
    input  logic        s_tuser,   // [0] req_type
    input  logic        s_tlast,
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [39:0] m_tdata,   // [31:0] digest_word, [34:32] word_index, zero fill
    output logic        m_tlast
);

    hs_pkg::item_t in_item;
    hs_pkg::item_t q_item;
    logic          q_valid;
    logic          q_ready;
    logic [31:0]   word;
    logic [2:0]    idx;

    assign in_item.req_type  = s_tuser;
    assign in_item.data_byte = s_tdata;
    assign in_item.last      = s_tlast;

    hs_front u_front
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .in_item   (in_item),
        .out_valid (q_valid),
        .out_ready (q_ready),
        .out_item  (q_item)
    );

    hs_back u_back
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (q_valid),
        .in_ready (q_ready),
        .in_item  (q_item),
        .m_valid  (m_tvalid),
        .m_ready  (m_tready),
        .m_word   (word),
        .m_idx    (idx),
        .m_last   (m_tlast)
    );

    assign m_tdata = {5'd0, idx, word};

endmodule
